### hw/rtl/dvrt_pkg.sv
package dvrt_pkg;

  // operation codes carried in the mode field
  localparam logic [1:0] MODE_HELLO   = 2'd0;
  localparam logic [1:0] MODE_UPDATE  = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;
  localparam logic [1:0] MODE_TIMEOUT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_LOCAL_ADDRESS     = 2'd0;
  localparam logic [1:0] REG_INFINITY_DISTANCE = 2'd1;
  localparam logic [1:0] REG_EXPIRY_TICKS      = 2'd2;

  localparam logic [7:0]  NoHop            = 8'd255;
  localparam logic [7:0]  LocalAddressRst  = 8'd0;
  localparam logic [7:0]  InfinityRst      = 8'd255;
  localparam logic [31:0] TimeoutRst       = 32'd30;
  localparam logic [7:0]  DirectDistance   = 8'd1;

  typedef struct packed {
    logic [7:0]  distance;
    logic [7:0]  hop;
    logic        has_hop;
    logic        neighbor;
    logic [31:0] hello_time;
  } route_entry_t;

  // contents of an entry never written since reset
  localparam route_entry_t EntryRst = '{
    distance:   InfinityRst,
    hop:        8'd0,
    has_hop:    1'b0,
    neighbor:   1'b0,
    hello_time: 32'd0
  };

endpackage

### hw/rtl/distance_vector_route_table.sv
// Distance-vector route table with poisoned reverse, one operation per input beat.
// Input channel (in_valid/in_ready) carries mode, source_node, dest_node,
// advertised_next_hop, advertised_distance and time_now. mode selects hello,
// update entry, next hop request or timeout check on one table entry.
// Output channel (out_valid/out_ready) returns exactly one result beat per input
// beat: route_hop, entry_changed, route_lost and ignored, in input order.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// local_address (0), infinity_distance (1) and expiry_ticks (2); it is
// always ready and is meant to be written while the block is idle.
// The entry read from the table memory for an input beat lands in a register,
// then one read-modify-write pass computes the result into the result register
// and writes the entry back. Throughput is one beat per cycle unless out_ready stalls;
// a back-to-back beat on the same node takes the written entry from a bypass.
// Reset clears the per-entry valid bits, so every entry reads as no route and no
// neighbor right away; there is no clearing pass. Registers return to 0, 255, 30.
// When the receiver stalls, the result register holds, the pipeline stage behind
// it holds, and in_ready drops once both are full.
module distance_vector_route_table #(
  parameter int NODE_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  source_node,
  input  logic [7:0]  dest_node,
  input  logic [7:0]  advertised_next_hop,
  input  logic [7:0]  advertised_distance,
  input  logic [31:0] time_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  route_hop,
  output logic        entry_changed,
  output logic        route_lost,
  output logic        ignored,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AddrWidth = $clog2(NODE_COUNT);
  localparam logic [7:0] NodeLimit = 8'(NODE_COUNT);

  // configuration
  logic [7:0]  local_address;
  logic [7:0]  infinity_distance;
  logic [31:0] expiry_ticks;

  // table memory and its valid bits
  dvrt_pkg::route_entry_t table_mem [NODE_COUNT];
  dvrt_pkg::route_entry_t rd_entry;
  logic [NODE_COUNT-1:0]  entry_valid;

  // pipeline stage holding the accepted beat
  logic                   s1_valid;
  logic [1:0]             s1_mode;
  logic [7:0]             s1_src;
  logic [7:0]             s1_dst;
  logic [7:0]             s1_adv_hop;
  logic [7:0]             s1_adv_dist;
  logic [31:0]            s1_time;
  logic                   fwd_hit;
  dvrt_pkg::route_entry_t fwd_entry;

  logic                   in_fire;
  logic                   s1_adv;
  logic [AddrWidth-1:0]   in_addr;
  logic [AddrWidth-1:0]   s1_addr;
  logic [7:0]             s1_node;
  logic                   s1_in_range;
  dvrt_pkg::route_entry_t cur_entry;
  dvrt_pkg::route_entry_t new_entry;
  logic                   do_write;
  logic                   wr_en;
  logic [8:0]             cand_dist;
  logic [31:0]            elapsed;
  logic [7:0]             route_hop_next;
  logic                   entry_changed_next;
  logic                   route_lost_next;
  logic                   ignored_next;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_fire   = in_valid && in_ready;

  // a hello addresses the sender, every other mode the destination
  assign in_addr = (mode == dvrt_pkg::MODE_HELLO) ? source_node[AddrWidth-1:0]
                                                  : dest_node[AddrWidth-1:0];
  assign s1_node = (s1_mode == dvrt_pkg::MODE_HELLO) ? s1_src : s1_dst;
  assign s1_addr = s1_node[AddrWidth-1:0];
  assign s1_in_range = s1_node < NodeLimit;

  always_comb begin
    if (fwd_hit) begin
      cur_entry = fwd_entry;
    end else if (entry_valid[s1_addr]) begin
      cur_entry = rd_entry;
    end else begin
      cur_entry = dvrt_pkg::EntryRst;
    end
  end

  assign cand_dist = {1'b0, s1_adv_dist} + 9'd1;
  assign elapsed   = s1_time - cur_entry.hello_time;

  always_comb begin
    new_entry          = cur_entry;
    do_write           = 1'b0;
    route_hop_next     = dvrt_pkg::NoHop;
    entry_changed_next = 1'b0;
    route_lost_next    = 1'b0;
    ignored_next       = 1'b0;
    case (s1_mode)
      dvrt_pkg::MODE_HELLO: begin
        if (!s1_in_range) begin
          ignored_next = 1'b1;
        end else begin
          do_write             = 1'b1;
          new_entry.neighbor   = 1'b1;
          new_entry.hello_time = s1_time;
          if (!cur_entry.has_hop) begin
            new_entry.has_hop  = 1'b1;
            new_entry.hop      = s1_src;
            new_entry.distance = dvrt_pkg::DirectDistance;
            entry_changed_next = 1'b1;
          end
        end
      end
      dvrt_pkg::MODE_UPDATE: begin
        // poisoned reverse: drop routes that go back through this node
        if (!s1_in_range || s1_adv_hop == local_address) begin
          ignored_next = 1'b1;
        end else if (cand_dist < {1'b0, cur_entry.distance}) begin
          do_write           = 1'b1;
          new_entry.distance = cand_dist[7:0];
          new_entry.hop      = s1_src;
          new_entry.has_hop  = 1'b1;
          entry_changed_next = 1'b1;
        end
      end
      dvrt_pkg::MODE_REQUEST: begin
        if (!s1_in_range) begin
          ignored_next = 1'b1;
        end else if (cur_entry.distance != infinity_distance && cur_entry.has_hop) begin
          route_hop_next = cur_entry.hop;
        end
      end
      dvrt_pkg::MODE_TIMEOUT: begin
        if (!s1_in_range) begin
          ignored_next = 1'b1;
        end else if (cur_entry.neighbor && elapsed > expiry_ticks) begin
          do_write           = 1'b1;
          new_entry.neighbor = 1'b0;
          new_entry.has_hop  = 1'b0;
          new_entry.hop      = 8'd0;
          new_entry.distance = infinity_distance;
          entry_changed_next = 1'b1;
          route_lost_next    = 1'b1;
        end
      end
      default: begin
        ignored_next = 1'b1;
      end
    endcase
  end

  assign wr_en = s1_adv && do_write;

  // table memory, registered read on input beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[s1_addr] <= new_entry;
    end
    if (in_fire) begin
      rd_entry <= table_mem[in_addr];
    end
  end

  // input stage and write bypass
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode     <= mode;
      s1_src      <= source_node;
      s1_dst      <= dest_node;
      s1_adv_hop  <= advertised_next_hop;
      s1_adv_dist <= advertised_distance;
      s1_time     <= time_now;
      fwd_hit     <= wr_en && (s1_addr == in_addr);
      fwd_entry   <= new_entry;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      route_hop     <= route_hop_next;
      entry_changed <= entry_changed_next;
      route_lost    <= route_lost_next;
      ignored       <= ignored_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      entry_valid       <= '0;
      local_address     <= dvrt_pkg::LocalAddressRst;
      infinity_distance <= dvrt_pkg::InfinityRst;
      expiry_ticks      <= dvrt_pkg::TimeoutRst;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        entry_valid[s1_addr] <= 1'b1;
      end
      if (cfg_valid) begin
        case (cfg_index)
          dvrt_pkg::REG_LOCAL_ADDRESS:     local_address     <= cfg_data[7:0];
          dvrt_pkg::REG_INFINITY_DISTANCE: infinity_distance <= cfg_data[7:0];
          dvrt_pkg::REG_EXPIRY_TICKS:      expiry_ticks      <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### hw/rtl/dvrt_checker.sv
module dvrt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] route_hop,
  input logic       entry_changed,
  input logic       route_lost,
  input logic       ignored
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(route_hop) && $stable(entry_changed)
      && $stable(route_lost) && $stable(ignored))
    else $error("result beat changed while stalled");

  // nothing comes out right after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // a lost route always rewrites the entry
  assert property (@(posedge clk) disable iff (rst)
    out_valid && route_lost |-> entry_changed && !ignored)
    else $error("route_lost without entry write");

  // a real next hop only comes from a request, which never writes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && route_hop != dvrt_pkg::NoHop |-> !entry_changed && !route_lost && !ignored)
    else $error("next hop answered on a writing operation");

  // an ignored beat changes nothing
  assert property (@(posedge clk) disable iff (rst)
    out_valid && ignored |-> !entry_changed && route_hop == dvrt_pkg::NoHop)
    else $error("ignored beat reported a change");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .route_hop     (route_hop),
  .entry_changed (entry_changed),
  .route_lost    (route_lost),
  .ignored       (ignored)
);
